[design/assert_macros.svh]
// assertion macros for the rtl files, included by the matcher (csf_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked at every rising clock edge outside reset
`define CSF_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication violated");

// next-cycle implication
`define CSF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication violated");

`else

`define CSF_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define CSF_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

[design/csf_pkg.sv]
// package: shared types, constants and case folding for the substring finder
`default_nettype none

package csf_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NEEDLE_LENGTH = 2'd0,
        CFG_NEEDLE_LOW    = 2'd1,
        CFG_NEEDLE_HIGH   = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned START_POS_BITS = 16;

    // one classified haystack byte, already folded to upper case
    typedef struct packed {
        logic       is_term;
        logic [7:0] data;
    } t_item;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/case_insensitive_substring_finder.sv]
// top level of the case-insensitive streaming substring finder
`default_nettype none

// streaming, case-insensitive substring search. haystack bytes come in one per
// request on the input channel; a zero byte ends the haystack. the needle (up to
// NEEDLE_MAX bytes) and its length are set through the config channel, which
// is always ready; only the low five bits of the length are used, and values
// above NEEDLE_MAX count as NEEDLE_MAX. ascii a-z is folded to upper case on
// both sides. per haystack the block returns at most one result: found=1 with
// the leftmost match start at the byte that completes it, or found=0 at the
// terminator when nothing matched. an empty needle reports found=1, start_pos=0
// on the first byte. the matcher sets the throughput, one byte per clock unless
// the result output stalls: it shifts the window and compares every needle byte
// in parallel, combinationally. a result passes through the front register,
// the queue and the result register before it is presented. a four-entry queue
// sits between the front stage and the matcher so each side stalls on its own.
// config must only be written while no haystack byte is in flight.

module case_insensitive_substring_finder #(
    parameter int unsigned NEEDLE_MAX    = 16,
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // haystack input
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_hay_byte,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [15:0]      o_start_pos,
    // config writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import csf_pkg::*;

    localparam int unsigned LW = $clog2(NEEDLE_MAX + 1);

    // needle length, already clamped to NEEDLE_MAX
    logic [LW-1:0]           r_len;
    logic [LW-1:0]           n_len;
    // needle bytes stored folded, byte 0 in the low bits
    logic [NEEDLE_MAX*8-1:0] r_needle;
    logic [NEEDLE_MAX*8-1:0] n_needle;
    logic                    cfg_wr;

    logic                    front_valid;
    logic                    front_ready;
    t_item                   front_item;
    logic                    queue_valid;
    logic                    queue_ready;
    t_item                   queue_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // next value of the config registers; unknown indexes fall through
    always_comb begin
        n_len    = r_len;
        n_needle = r_needle;
        case (t_cfg_index'(i_cfg_index))
            CFG_NEEDLE_LENGTH: begin
                if (i_cfg_data[4:0] > 5'(NEEDLE_MAX)) begin
                    n_len = LW'(NEEDLE_MAX);
                end else begin
                    n_len = LW'(i_cfg_data[4:0]);
                end
            end
            CFG_NEEDLE_LOW: begin
                for (int k = 0; k < NEEDLE_MAX; k++) begin
                    if (k < 8) begin
                        n_needle[8*k +: 8] = fold_upper(i_cfg_data[8*(k%8) +: 8]);
                    end
                end
            end
            CFG_NEEDLE_HIGH: begin
                for (int k = 0; k < NEEDLE_MAX; k++) begin
                    if (k >= 8) begin
                        n_needle[8*k +: 8] = fold_upper(i_cfg_data[8*(k%8) +: 8]);
                    end
                end
            end
            default: begin
                n_len    = r_len;
                n_needle = r_needle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_needle <= '0;
        end else if (cfg_wr) begin
            r_len    <= n_len;
            r_needle <= n_needle;
        end
    end

    // front: register the request, fold and flag the terminator
    csf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_hay_byte (i_hay_byte),
        .o_valid    (front_valid),
        .i_ready    (front_ready),
        .o_item     (front_item)
    );

    // decoupling queue
    csf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    // back: window compare, position count, result register
    csf_back #(
        .NEEDLE_MAX    (NEEDLE_MAX),
        .POSITION_BITS (POSITION_BITS),
        .LW            (LW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .o_ready     (queue_ready),
        .i_item      (queue_item),
        .i_len       (r_len),
        .i_needle    (r_needle),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_found     (o_found),
        .o_start_pos (o_start_pos)
    );

endmodule

`default_nettype wire

[design/csf_front.sv]
// front stage: takes haystack bytes, folds case and marks the terminator
`default_nettype none

module csf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_hay_byte,
    output logic               o_valid,
    input  wire logic          i_ready,
    output csf_pkg::t_item     o_item
);
    import csf_pkg::*;

    logic  r_valid;
    t_item r_item;

    // stage frees up when empty or when the queue takes its request
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.is_term <= (i_hay_byte == 8'h00);
            r_item.data    <= fold_upper(i_hay_byte);
        end
    end

endmodule

`default_nettype wire

[design/csf_queue.sv]
// small fifo between the front stage and the matcher
`default_nettype none

module csf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  csf_pkg::t_item     i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output csf_pkg::t_item     o_item
);
    import csf_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/csf_back.sv]
// matcher: byte window, parallel needle compare, position count, result register
`default_nettype none
`include "assert_macros.svh"

module csf_back #(
    parameter int unsigned NEEDLE_MAX    = 16,
    parameter int unsigned POSITION_BITS = 16,
    parameter int unsigned LW            = $clog2(NEEDLE_MAX + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  csf_pkg::t_item                 i_item,
    input  wire logic [LW-1:0]             i_len,
    input  wire logic [NEEDLE_MAX*8-1:0]   i_needle,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_found,
    output logic [csf_pkg::START_POS_BITS-1:0] o_start_pos
);
    import csf_pkg::*;

    localparam int unsigned IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int unsigned PB = POSITION_BITS;

    logic [7:0]          r_window [NEEDLE_MAX];
    logic [7:0]          n_window [NEEDLE_MAX];
    logic [PB-1:0]       r_seen;
    logic [PB-1:0]       n_seen;
    logic                r_reported;
    logic                n_reported;
    logic                r_out_valid;
    logic                r_found;
    logic [START_POS_BITS-1:0] r_start_pos;

    logic                pop;
    logic                produce;
    logic                res_found;
    logic [START_POS_BITS-1:0] res_pos;
    logic [NEEDLE_MAX-1:0] hit;
    logic                window_match;
    logic [LW-1:0]       sel_diff;
    logic [IW-1:0]       sel_idx;
    logic [PB-1:0]       pos_diff;
    logic [PB+START_POS_BITS-1:0] pos_ext;

    assign o_ready     = !r_out_valid || i_ready;
    assign pop         = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_start_pos = r_start_pos;

    // window after the current byte is shifted in, newest at entry zero
    always_comb begin
        n_window[0] = i_item.data;
        for (int k = 1; k < NEEDLE_MAX; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    assign n_seen = (r_seen == '1) ? r_seen : r_seen + 1'b1;

    // needle byte i lines up with the byte received len-1-i items ago
    always_comb begin
        hit      = '0;
        sel_diff = '0;
        sel_idx  = '0;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            sel_diff = i_len - LW'(i) - LW'(1);
            sel_idx  = sel_diff[IW-1:0];
            hit[i]   = (LW'(i) >= i_len) || (n_window[sel_idx] == i_needle[8*i +: 8]);
        end
    end

    assign window_match = (&hit) && (n_seen >= PB'(i_len));
    assign pos_diff     = n_seen - PB'(i_len);
    assign pos_ext      = {{START_POS_BITS{1'b0}}, pos_diff};

    // classify the request and decide on a result
    always_comb begin
        produce    = 1'b0;
        res_found  = 1'b0;
        res_pos    = '0;
        n_reported = r_reported;
        if (!r_reported && i_len == '0) begin
            produce    = 1'b1;
            res_found  = 1'b1;
            n_reported = !i_item.is_term;
        end else if (i_item.is_term) begin
            produce    = !r_reported;
            n_reported = 1'b0;
        end else if (!r_reported && window_match) begin
            produce    = 1'b1;
            res_found  = 1'b1;
            res_pos    = pos_ext[START_POS_BITS-1:0];
            n_reported = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_reported <= n_reported;
                if (i_item.is_term) begin
                    r_seen <= '0;
                end else if (!r_reported) begin
                    r_seen <= n_seen;
                end
            end
            if (pop && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window bytes are only compared below the fill count, so no reset
    always_ff @(posedge i_clk) begin
        if (pop && !i_item.is_term && !r_reported) begin
            r_window <= n_window;
        end
        if (pop && produce) begin
            r_found     <= res_found;
            r_start_pos <= res_pos;
        end
    end

    `CSF_ASSERT_IMPL(a_notfound_pos_zero, i_clk, i_rst_n, r_out_valid && !r_found, r_start_pos == '0)
    `CSF_ASSERT_NEXT(a_term_clears, i_clk, i_rst_n, pop && i_item.is_term, (r_seen == '0) && !r_reported)
    `CSF_ASSERT_NEXT(a_found_sets_flag, i_clk, i_rst_n, pop && produce && !i_item.is_term, r_reported)
    `CSF_ASSERT_IMPL(a_miss_only_on_term, i_clk, i_rst_n, pop && produce && !res_found, i_item.is_term)

endmodule

`default_nettype wire
